@@ src/dpsk_pkg.sv @@
// Shared types, constants and table functions for the DPSK pulse-shaping modulator.
`timescale 1ns / 1ps

package dpsk_pkg;

    localparam int PROTO_LEN = 33;

    // Right half of a raised-cosine pulse, beta 0.5, 16 samples per symbol, Q1.15
    localparam int PROTO_SHAPE [PROTO_LEN] = '{
        32767, 32528, 31816, 30652, 29073, 27124, 24863, 22354,
        19668, 16878, 14057, 11276, 8602, 6092, 3797, 1757,
        0, -1456, -2606, -3454, -4014, -4310, -4372, -4234,
        -3934, -3511, -3005, -2453, -1888, -1339, -830, -380,
        0
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // shift a new symbol into the history
        logic issue;  // start one sample down the pipeline
        logic last;   // issued sample closes the run
    } dp_cmd_t;

    // sin(pi/2 * x), x and result in Q30
    function automatic longint unsigned quarter_sine(longint unsigned x);
        longint unsigned y;
        longint unsigned t;
        y = (x * x) >> 30;
        t = 64'd172272;
        t = 64'd5026994 - ((y * t) >> 30);
        t = 64'd85569306 - ((y * t) >> 30);
        t = 64'd693598669 - ((y * t) >> 30);
        t = 64'd1686629713 - ((y * t) >> 30);
        return (x * t) >> 30;
    endfunction

endpackage

@@ src/dpsk_pulse_shaping_modulator.sv @@
// Usage notes:
// Symbol channel (sym_valid/sym_stall) carries func and data_bit: func 0 sends
// data_bit differentially encoded (1 flips the carrier sign), func 1 sends silence.
// Each symbol transaction produces SAMPLES_PER_SYMBOL sample transactions on the
// sample channel (smp_valid/smp_stall), last marking the final one of the run.
// The run controller issues one sample per cycle unless the sample channel
// stalls; the next symbol is taken in the cycle of the previous run's final
// issue. Each sample passes through the shaping sum, sine ROM read, multiply
// and round/saturate stages, each registered, before it appears.
// The carrier phase advances once per sample and runs freely across symbols.
// cfg_data loads carrier_step whenever cfg_valid is high (cfg_ready is always
// high); write only while no run is in flight.
// A stall on the sample channel freezes the whole pipeline and the run counter.
// Reset clears history to silence, sign to +1, phase to 0, carrier_step to 2^29.
`timescale 1ns / 1ps

module dpsk_pulse_shaping_modulator #(
    parameter int SAMPLES_PER_SYMBOL = 16,
    parameter int SINE_TABLE_DEPTH   = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_stall,
    input  logic               func,
    input  logic               data_bit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    output logic               smp_valid,
    input  logic               smp_stall,
    output logic signed [15:0] sample,
    output logic               last
);
    import dpsk_pkg::*;

    localparam int KW = $clog2(SAMPLES_PER_SYMBOL);

    dp_cmd_t        cmd;
    logic [KW-1:0]  k;
    logic           adv;

    assign cfg_ready = 1'b1;

    dpsk_ctrl #(
        .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .adv       (adv),
        .cmd       (cmd),
        .k         (k)
    );

    dpsk_dp #(
        .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
        .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .k         (k),
        .adv       (adv),
        .func      (func),
        .data_bit  (data_bit),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .sample    (sample),
        .last      (last)
    );

endmodule

@@ src/dpsk_ctrl.sv @@
// Run controller: accepts symbols and sequences the samples of each run.
`timescale 1ns / 1ps

module dpsk_ctrl #(
    parameter int SAMPLES_PER_SYMBOL = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sym_valid,
    output logic                                   sym_stall,
    input  logic                                   adv,
    output dpsk_pkg::dp_cmd_t                      cmd,
    output logic [$clog2(SAMPLES_PER_SYMBOL)-1:0]  k
);
    import dpsk_pkg::*;

    localparam int KW = $clog2(SAMPLES_PER_SYMBOL);
    localparam logic [KW-1:0] K_LAST = KW'(SAMPLES_PER_SYMBOL - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t          state_reg;
    logic [KW-1:0]   k_reg;
    logic            at_last;
    logic            accept;

    assign at_last   = (k_reg == K_LAST);
    assign sym_stall = !((state_reg == ST_IDLE) || (state_reg == ST_RUN && at_last && adv));
    assign accept    = sym_valid && !sym_stall;

    assign cmd.load  = accept;
    assign cmd.issue = (state_reg == ST_RUN) && adv;
    assign cmd.last  = at_last;
    assign k         = k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            priority if (accept)
            begin
                state_reg <= ST_RUN;
                k_reg     <= '0;
            end
            else if (cmd.issue)
            begin
                if (at_last)
                begin
                    state_reg <= ST_IDLE;
                    k_reg     <= '0;
                end
                else
                begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            else
            begin
                state_reg <= state_reg;
                k_reg     <= k_reg;
            end
        end
    end

endmodule

@@ src/dpsk_dp.sv @@
// Datapath: symbol history, shaping ROM, carrier oscillator and sample pipeline.
`timescale 1ns / 1ps

module dpsk_dp #(
    parameter int SAMPLES_PER_SYMBOL = 16,
    parameter int SINE_TABLE_DEPTH   = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dpsk_pkg::dp_cmd_t                      cmd,
    input  logic [$clog2(SAMPLES_PER_SYMBOL)-1:0]  k,
    output logic                                   adv,
    input  logic                                   func,
    input  logic                                   data_bit,
    input  logic                                   cfg_valid,
    input  logic [31:0]                            cfg_data,
    output logic                                   smp_valid,
    input  logic                                   smp_stall,
    output logic signed [15:0]                     sample,
    output logic                                   last
);
    import dpsk_pkg::*;

    localparam int SHAPE_LEN = 2 * SAMPLES_PER_SYMBOL + 1;
    localparam int SW        = $clog2(SHAPE_LEN);
    localparam int IW        = $clog2(SINE_TABLE_DEPTH);
    localparam int PW        = 32 + IW + 1;
    localparam logic [31:0] STEP_RESET = 32'h2000_0000;

    typedef enum logic [1:0] {
        SYM_ZERO = 2'b00,
        SYM_POS  = 2'b01,
        SYM_NEG  = 2'b11
    } sym_t;

    function automatic logic signed [15:0] shape_at(int i);
        int num;
        int idx;
        int frac;
        int base;
        int nxt;
        num  = i * 16;
        idx  = num / SAMPLES_PER_SYMBOL;
        frac = num - idx * SAMPLES_PER_SYMBOL;
        if (idx > 32)
            idx = 32;
        base = PROTO_SHAPE[idx];
        nxt  = (idx < 32) ? PROTO_SHAPE[idx + 1] : base;
        return 16'(base + ((nxt - base) * frac) / SAMPLES_PER_SYMBOL);
    endfunction

    function automatic logic signed [15:0] sine_at(int i);
        longint unsigned four;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned v;
        four = longint'(i) * 4;
        quad = four / SINE_TABLE_DEPTH;
        rem  = four - quad * SINE_TABLE_DEPTH;
        if (quad[0])
            rem = SINE_TABLE_DEPTH - rem;
        x = (rem << 30) / SINE_TABLE_DEPTH;
        v = (quarter_sine(x) + 64'd16384) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        return quad[1] ? -16'(v) : 16'(v);
    endfunction

    function automatic logic signed [17:0] term(sym_t s, logic signed [15:0] v);
        logic signed [17:0] r;
        unique case (s)
            SYM_POS: r = 18'(v);
            SYM_NEG: r = -18'(v);
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [15:0] shape_rom [SHAPE_LEN];
    logic signed [15:0] sine_rom  [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SHAPE_LEN; g++)
    begin : g_shape
        assign shape_rom[g] = shape_at(g);
    end

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_sine
        assign sine_rom[g] = sine_at(g);
    end

    // State
    logic [31:0]  step_reg;
    logic [31:0]  phase_reg;
    logic         sign_reg;
    sym_t         hist_reg [4];
    logic         sign_next;
    sym_t         sym_next;

    // Pipeline
    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                 l1_reg, l2_reg, l3_reg, out_last_reg;
    logic signed [17:0]   sum1_reg, sum2_reg;
    logic [IW-1:0]        sidx1_reg;
    logic signed [15:0]   sine2_reg;
    logic signed [33:0]   prod3_reg;
    logic signed [15:0]   sample_reg;

    logic [SW-1:0]        ia, ib, ic, id;
    logic signed [17:0]   sum_next;
    logic [PW-1:0]        phase_prod;
    logic signed [34:0]   biased;
    logic signed [18:0]   rounded;
    logic signed [15:0]   sample_next;

    assign adv = !(out_valid_reg && smp_stall);

    assign sign_next = sign_reg ^ data_bit;
    assign sym_next  = func ? SYM_ZERO : (sign_next ? SYM_NEG : SYM_POS);

    assign ia = SW'(SAMPLES_PER_SYMBOL) + SW'(k);
    assign ib = SW'(k);
    assign ic = SW'(SAMPLES_PER_SYMBOL) - SW'(k);
    assign id = SW'(2 * SAMPLES_PER_SYMBOL) - SW'(k);

    assign sum_next = term(hist_reg[0], shape_rom[ia]) + term(hist_reg[1], shape_rom[ib])
                    + term(hist_reg[2], shape_rom[ic]) + term(hist_reg[3], shape_rom[id]);

    assign phase_prod = PW'(phase_reg) * PW'(SINE_TABLE_DEPTH);

    assign biased  = 35'(prod3_reg) + 35'sd32768;
    assign rounded = 19'(biased >>> 16);

    always_comb
    begin
        priority if (rounded > 19'sd32767)
            sample_next = 16'sh7FFF;
        else if (rounded < -19'sd32768)
            sample_next = -16'sh8000;
        else
            sample_next = 16'(rounded);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_RESET;
            phase_reg <= '0;
            sign_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= SYM_ZERO;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                step_reg <= cfg_data;
            if (cmd.load)
            begin
                if (!func)
                    sign_reg <= sign_next;
                hist_reg[0] <= hist_reg[1];
                hist_reg[1] <= hist_reg[2];
                hist_reg[2] <= hist_reg[3];
                hist_reg[3] <= sym_next;
            end
            if (cmd.issue)
                phase_reg <= phase_reg + step_reg;
            if (adv)
            begin
                v1_reg        <= cmd.issue;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum1_reg     <= sum_next;
            sidx1_reg    <= phase_prod[32 +: IW];
            l1_reg       <= cmd.last;
            sine2_reg    <= sine_rom[sidx1_reg];
            sum2_reg     <= sum1_reg;
            l2_reg       <= l1_reg;
            prod3_reg    <= 34'(sum2_reg) * 34'(sine2_reg);
            l3_reg       <= l2_reg;
            sample_reg   <= sample_next;
            out_last_reg <= l3_reg;
        end
    end

    assign smp_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = out_last_reg;

endmodule

@@ src/dpsk_checker.sv @@
// Port-level checker for the DPSK pulse-shaping modulator, with its bind.
`timescale 1ns / 1ps

module dpsk_checker #(
    parameter int SAMPLES_PER_SYMBOL = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               sym_valid,
    input logic               sym_stall,
    input logic               smp_valid,
    input logic               smp_stall,
    input logic signed [15:0] sample,
    input logic               last
);
    localparam int CW = $clog2(SAMPLES_PER_SYMBOL);
    localparam logic [CW-1:0] C_LAST = CW'(SAMPLES_PER_SYMBOL - 1);

    logic [CW-1:0] cnt_reg;
    logic          smp_xfer;
    logic          sym_xfer;

    assign smp_xfer = smp_valid && !smp_stall;
    assign sym_xfer = sym_valid && !sym_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (smp_xfer)
            cnt_reg <= last ? '0 : cnt_reg + CW'(1);
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !smp_valid)
        else $error("sample valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_stall |=> smp_valid && $stable(sample) && $stable(last))
        else $error("stalled sample transaction changed");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        smp_xfer |-> (last == (cnt_reg == C_LAST)))
        else $error("last flag out of place in run");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sym_xfer |=> sym_stall)
        else $error("symbol taken while a run was starting");

endmodule

bind dpsk_pulse_shaping_modulator dpsk_checker #(
    .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL)
) u_dpsk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .sample    (sample),
    .last      (last)
);
